>>> src/assert_macros.svh
// Concurrent assertion helpers; expect clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold cond at every edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// cause in one cycle implies effect in the same cycle.
`define ASSERT_IMPL(label, cause, effect, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cause) |-> (effect)) \
      else $error(msg);

// cause in one cycle implies effect in the next cycle.
`define ASSERT_NEXT(label, cause, effect, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) \
      else $error(msg);

`endif

>>> src/edrg_pkg.sv
package edrg_pkg;

   localparam logic [1:0] FUNC_MIC  = 2'd0;
   localparam logic [1:0] FUNC_RX   = 2'd1;
   localparam logic [1:0] FUNC_IDLE = 2'd2;

   localparam logic CH_MIC = 1'b0;
   localparam logic CH_SPK = 1'b1;

   localparam logic [1:0] REG_RX_GAIN   = 2'd0;
   localparam logic [1:0] REG_DUCK_GAIN = 2'd1;
   localparam logic [1:0] REG_THRESHOLD = 2'd2;
   localparam logic [1:0] REG_HANGOVER  = 2'd3;

   localparam logic [11:0] RX_GAIN_RESET   = 12'd256;
   localparam logic [8:0]  DUCK_GAIN_RESET = 9'd256;
   localparam logic [15:0] THRESHOLD_RESET = 16'd1000;
   localparam logic [7:0]  HANGOVER_RESET  = 8'd10;

   localparam logic [8:0] DUCK_UNITY = 9'd256;

   localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [15:0] SAMPLE_MIN = -16'sh8000;

   localparam int SUM_W = 23;

   typedef struct packed {
      logic [11:0] rx_gain;
      logic [8:0]  duck_gain;
      logic [15:0] duck_threshold;
      logic [7:0]  hangover_frames;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [15:0] sample;
      logic               frame_end;
   } item_type;

   typedef struct packed {
      logic               channel;
      logic signed [15:0] sample_out;
      logic               frame_end_out;
      logic               ducked;
   } result_type;

endpackage

>>> src/edrg_csr.sv
module edrg_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   output edrg_pkg::cfg_type  cfg
);
   import edrg_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] index;

   assign index      = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_RX_GAIN:   cfg_in.rx_gain         = csr_pwdata[11:0];
            REG_DUCK_GAIN: cfg_in.duck_gain       = csr_pwdata[8:0];
            REG_THRESHOLD: cfg_in.duck_threshold  = csr_pwdata[15:0];
            REG_HANGOVER:  cfg_in.hangover_frames = csr_pwdata[7:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_RX_GAIN:   csr_prdata = {20'd0, cfg_ff.rx_gain};
         REG_DUCK_GAIN: csr_prdata = {23'd0, cfg_ff.duck_gain};
         REG_THRESHOLD: csr_prdata = {16'd0, cfg_ff.duck_threshold};
         REG_HANGOVER:  csr_prdata = {24'd0, cfg_ff.hangover_frames};
         default:       csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rx_gain         <= RX_GAIN_RESET;
         cfg_ff.duck_gain       <= DUCK_GAIN_RESET;
         cfg_ff.duck_threshold  <= THRESHOLD_RESET;
         cfg_ff.hangover_frames <= HANGOVER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> src/edrg_core.sv
module edrg_core #(
   parameter int FRAME_SAMPLES = 160
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  edrg_pkg::item_type    item,
   input  edrg_pkg::cfg_type     cfg,
   output logic                  result_valid,
   output edrg_pkg::result_type  result
);
   import edrg_pkg::*;

   localparam int CW    = $clog2(FRAME_SAMPLES + 1);
   localparam int LW    = 17 + CW;
   localparam int CMP_W = (LW > SUM_W) ? LW : SUM_W;

   logic [7:0]       hang_ff, hang_in;
   logic             latched_ff, latched_in;
   logic             mic_mid_ff, mic_mid_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CW-1:0]    count_ff, count_in;

   logic               is_mic;
   logic               latched_now;
   logic [11:0]        gain_sel;
   logic signed [12:0] gain_s;
   logic signed [28:0] prod;
   logic signed [20:0] quot;
   logic signed [15:0] scaled;
   logic [16:0]        mag;
   logic [SUM_W:0]     sum_wide;
   logic [SUM_W-1:0]   sum_sat;
   logic [CW-1:0]      count_next;
   logic [16:0]        thr_plus;
   logic [LW-1:0]      limit;
   logic               frame_done;
   logic               talking;

   assign is_mic      = (item.func == FUNC_MIC);
   assign latched_now = mic_mid_ff ? latched_ff : (hang_ff != 8'd0);

   // Shared Q8 scaler: floor by arithmetic shift, then clamp to 16 bits.
   assign gain_sel = is_mic ? {3'd0, cfg.duck_gain} : cfg.rx_gain;
   assign gain_s   = $signed({1'b0, gain_sel});
   assign prod     = item.sample * gain_s;
   assign quot     = prod[28:8];

   always_comb begin
      if (quot[20:15] == 6'b000000 || quot[20:15] == 6'b111111) begin
         scaled = quot[15:0];
      end else if (quot[20]) begin
         scaled = SAMPLE_MIN;
      end else begin
         scaled = SAMPLE_MAX;
      end
   end

   assign mag        = item.sample[15] ? 17'(-{item.sample[15], item.sample})
                                       : {1'b0, item.sample};
   assign sum_wide   = {1'b0, sum_ff} + (SUM_W + 1)'(mag);
   assign sum_sat    = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
   assign count_next = count_ff + 1'b1;
   assign thr_plus   = {1'b0, cfg.duck_threshold} + 17'd1;
   assign limit      = LW'(thr_plus) * LW'(count_next);
   assign frame_done = item.frame_end || (count_next >= CW'(FRAME_SAMPLES));
   assign talking    = (CMP_W'(sum_sat) >= CMP_W'(limit)) && (cfg.duck_gain != DUCK_UNITY);

   always_comb begin
      hang_in    = hang_ff;
      latched_in = latched_ff;
      mic_mid_in = mic_mid_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;

      result_valid         = 1'b0;
      result.channel       = CH_MIC;
      result.sample_out    = item.sample;
      result.frame_end_out = item.frame_end;
      result.ducked        = 1'b0;

      case (item.func)
         FUNC_MIC: begin
            result_valid      = 1'b1;
            latched_in        = latched_now;
            result.ducked     = latched_now;
            result.sample_out = latched_now ? scaled : item.sample;
            mic_mid_in        = !item.frame_end;
            if (item.frame_end && latched_now && hang_ff != 8'd0) begin
               hang_in = hang_ff - 8'd1;
            end
         end
         FUNC_RX: begin
            result_valid      = 1'b1;
            result.channel    = CH_SPK;
            result.sample_out = scaled;
            if (frame_done) begin
               if (talking) begin
                  hang_in = cfg.hangover_frames;
               end
               sum_in   = '0;
               count_in = '0;
            end else begin
               sum_in   = sum_sat;
               count_in = count_next;
            end
         end
         FUNC_IDLE: begin
            hang_in    = 8'd0;
            latched_in = 1'b0;
            mic_mid_in = 1'b0;
            sum_in     = '0;
            count_in   = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hang_ff    <= 8'd0;
         latched_ff <= 1'b0;
         mic_mid_ff <= 1'b0;
         sum_ff     <= '0;
         count_ff   <= '0;
      end else if (step) begin
         hang_ff    <= hang_in;
         latched_ff <= latched_in;
         mic_mid_ff <= mic_mid_in;
         sum_ff     <= sum_in;
         count_ff   <= count_in;
      end
   end

`include "assert_macros.svh"

   `ASSERT_ALWAYS(a_count_in_frame, count_ff < CW'(FRAME_SAMPLES), "rx count past frame length")
   `ASSERT_IMPL(a_ducked_is_mic, result_valid && result.ducked, result.channel == CH_MIC, "ducked speaker sample")
   `ASSERT_NEXT(a_idle_clears, step && item.func == FUNC_IDLE, hang_ff == 8'd0 && !mic_mid_ff && count_ff == '0, "idle left state")

endmodule

>>> src/echo_duck_and_rx_gain.sv
// Channel  | Direction | Payload
// req_     | in        | tuser: func[1:0]; tdata: sample[15:0]; tlast: frame_end
// rsp_     | out       | tuser: channel, ducked; tdata: sample_out[15:0]; tlast: frame_end_out
// csr_     | in        | APB registers rx_gain, duck_gain, duck_threshold, hangover_frames
//
// One transaction per cycle while rsp_ is not stalled; req_ passes through the input register,
// then the core's combinational scale/accumulate/compare into the output register to rsp_.
// Idle transactions clear ducking state; idle and unused selector ones produce no result.
// A stall on rsp_ holds both stages; req_tready falls only when both are full.
// Reset is synchronous and clears all ducking state; registers return to defaults.
module echo_duck_and_rx_gain #(
   parameter int FRAME_SAMPLES = 160
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // sample[15:0]
   input  logic [1:0]   req_tuser,   // func[1:0]
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,   // sample_out[15:0]
   output logic [1:0]   rsp_tuser,   // channel, ducked
   output logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import edrg_pkg::*;

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       in_valid_ff, in_valid_in;
   result_type out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   result_type core_result;
   logic       core_valid;
   logic       advance;
   logic       step;

   edrg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   edrg_core #(
      .FRAME_SAMPLES (FRAME_SAMPLES)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .item         (item_ff),
      .cfg          (cfg),
      .result_valid (core_valid),
      .result       (core_result)
   );

   assign advance    = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         item_in     = '{func: req_tuser, sample: req_tdata, frame_end: req_tlast};
      end
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = step && core_valid;
         out_in       = core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      out_ff  <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.sample_out;
   assign rsp_tuser  = {out_ff.ducked, out_ff.channel};
   assign rsp_tlast  = out_ff.frame_end_out;

`include "assert_macros.svh"

   `ASSERT_NEXT(a_idle_no_result, step && item_ff.func == FUNC_IDLE, !rsp_tvalid, "result from idle")

endmodule

>>> tb/sv/duck_gain_checker.sv
`timescale 1ns / 100ps

module duck_gain_checker #(
   parameter int FRAME_SAMPLES = 160
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [15:0]  req_tdata,   // sample[15:0]
   input  logic [1:0]   req_tuser,   // func[1:0]
   input  logic         req_tlast,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [15:0]  rsp_tdata,   // sample_out[15:0]
   input  logic [1:0]   rsp_tuser,   // channel, ducked
   input  logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic         csr_pready,
   output int           mismatches,
   output int           pending
);
   import edrg_pkg::*;

   localparam longint unsigned LEVEL_SUM_MAX = (longint'(1) << SUM_W) - 1;

   cfg_type            cfg;
   logic [7:0]         hangover_left;
   logic               duck_active;
   logic               mic_in_frame;
   logic [SUM_W-1:0]   rx_level_sum;
   int                 rx_samples;
   result_type         expected_samples[$];

   function automatic logic signed [15:0] scale_q8_sat(logic signed [15:0] s, int g);
      int prod;
      int q;
      prod = int'(s) * g;
      q = prod >>> 8;
      if (q > int'(SAMPLE_MAX))
         return SAMPLE_MAX;
      if (q < int'(SAMPLE_MIN))
         return SAMPLE_MIN;
      return q[15:0];
   endfunction

   task automatic clear_ducking();
      hangover_left = '0;
      duck_active = 1'b0;
      mic_in_frame = 1'b0;
      rx_level_sum = '0;
      rx_samples = 0;
   endtask

   task automatic predict_transaction(item_type it);
      result_type     r;
      int             mag;
      longint         total;
      longint         bound;
      case (it.func)
         FUNC_MIC: begin
            if (!mic_in_frame)
               duck_active = (hangover_left != 0);
            r.channel = CH_MIC;
            r.sample_out = duck_active ? scale_q8_sat(it.sample, int'(cfg.duck_gain))
                                       : it.sample;
            r.frame_end_out = it.frame_end;
            r.ducked = duck_active;
            if (it.frame_end) begin
               if (duck_active && hangover_left != 0)
                  hangover_left = hangover_left - 8'd1;
               mic_in_frame = 1'b0;
            end else begin
               mic_in_frame = 1'b1;
            end
            expected_samples.push_back(r);
         end
         FUNC_RX: begin
            mag = (it.sample < 0) ? -int'(it.sample) : int'(it.sample);
            total = longint'(rx_level_sum) + mag;
            rx_level_sum = (total > LEVEL_SUM_MAX) ? LEVEL_SUM_MAX[SUM_W-1:0]
                                                   : total[SUM_W-1:0];
            rx_samples++;
            if (it.frame_end || rx_samples >= FRAME_SAMPLES) begin
               bound = (longint'(cfg.duck_threshold) + 1) * rx_samples;
               if (longint'(rx_level_sum) >= bound && cfg.duck_gain != DUCK_UNITY)
                  hangover_left = cfg.hangover_frames;
               rx_level_sum = '0;
               rx_samples = 0;
            end
            r.channel = CH_SPK;
            r.sample_out = scale_q8_sat(it.sample, int'(cfg.rx_gain));
            r.frame_end_out = it.frame_end;
            r.ducked = 1'b0;
            expected_samples.push_back(r);
         end
         FUNC_IDLE: begin
            clear_ducking();
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : monitor
      item_type   it;
      result_type got;
      result_type want;
      if (reset) begin
         cfg = '{RX_GAIN_RESET, DUCK_GAIN_RESET, THRESHOLD_RESET, HANGOVER_RESET};
         clear_ducking();
         expected_samples.delete();
         mismatches = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_RX_GAIN:   cfg.rx_gain = csr_pwdata[11:0];
               REG_DUCK_GAIN: cfg.duck_gain = csr_pwdata[8:0];
               REG_THRESHOLD: cfg.duck_threshold = csr_pwdata[15:0];
               REG_HANGOVER:  cfg.hangover_frames = csr_pwdata[7:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.channel = rsp_tuser[0];
            got.ducked = rsp_tuser[1];
            got.sample_out = rsp_tdata;
            got.frame_end_out = rsp_tlast;
            if (expected_samples.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected rsp transaction: channel %0d sample %0d last %0d ducked %0d",
                           got.channel, got.sample_out, got.frame_end_out, got.ducked);
            end else begin
               want = expected_samples.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("rsp mismatch: expected channel %0d sample %0d last %0d ducked %0d",
                              want.channel, want.sample_out, want.frame_end_out, want.ducked);
                     $display("              got channel %0d sample %0d last %0d ducked %0d",
                              got.channel, got.sample_out, got.frame_end_out, got.ducked);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            it.func = req_tuser;
            it.sample = req_tdata;
            it.frame_end = req_tlast;
            predict_transaction(it);
         end
      end
      pending = expected_samples.size();
   end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import edrg_pkg::*;

   localparam int FRAME_SAMPLES = 160;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 6;
   localparam int PHASES = 12;
   localparam int PHASE_ITEMS = 84;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [15:0]  req_tdata = '0;
   logic [1:0]   req_tuser = FUNC_MIC;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b1;
   logic [15:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [3:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   logic         calm = 1'b0;
   int           stall_left = 0;
   int           mismatch_count;
   int           pending_results;

   echo_duck_and_rx_gain #(
      .FRAME_SAMPLES(FRAME_SAMPLES)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   duck_gain_checker #(
      .FRAME_SAMPLES(FRAME_SAMPLES)
   ) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .mismatches  (mismatch_count),
      .pending     (pending_results)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stall the result channel in random bursts
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 15);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   task automatic send_transaction(logic [1:0] func, logic [15:0] sample, logic last);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= sample;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_register(logic [1:0] index, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   // hold off until every result is out, then let the pipeline empty
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_results != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic apply_settings(logic [11:0] rx_gain, logic [8:0] duck_gain,
                                 logic [15:0] threshold, logic [7:0] hangover);
      drain_results();
      write_register(REG_RX_GAIN, 32'(rx_gain));
      write_register(REG_DUCK_GAIN, 32'(duck_gain));
      write_register(REG_THRESHOLD, 32'(threshold));
      write_register(REG_HANGOVER, 32'(hangover));
   endtask

   function automatic logic [15:0] pick_sample(int amp);
      int v;
      v = int'($urandom_range(0, 2 * amp)) - amp;
      return v[15:0];
   endfunction

   function automatic int pick_level();
      if ($urandom_range(0, 5) == 0)
         return 32768;
      return int'($urandom_range(0, 32768) >> $urandom_range(0, 15));
   endfunction

   task automatic send_frame(logic [1:0] func, int len, int amp, logic close);
      for (int i = 0; i < len; i++)
         send_transaction(func, pick_sample(amp), close && (i == len - 1));
   endtask

   initial begin : stimulus
      int kind;
      int len;
      int sent;
      logic [11:0] rxg;
      logic [8:0]  dg;
      logic [15:0] thr;
      logic [7:0]  hang;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      apply_settings(12'd4095, 9'd128, 16'd32767, 8'd2);
      send_transaction(FUNC_RX, SAMPLE_MIN, 1'b0);
      send_transaction(FUNC_RX, SAMPLE_MIN, 1'b1);
      send_transaction(FUNC_RX, SAMPLE_MAX, 1'b1);
      send_transaction(FUNC_MIC, SAMPLE_MAX, 1'b0);
      send_transaction(FUNC_MIC, SAMPLE_MIN, 1'b1);
      send_transaction(FUNC_MIC, 16'hFFFF, 1'b1);
      send_transaction(FUNC_MIC, 16'd100, 1'b1);
      send_transaction(FUNC_RX, 16'd0, 1'b1);
      send_transaction(FUNC_RX, 16'd1, 1'b1);
      send_transaction(FUNC_UNUSED, 16'hFFFF, 1'b1);
      send_transaction(FUNC_RX, SAMPLE_MIN, 1'b1);
      send_transaction(FUNC_MIC, 16'd5, 1'b0);
      send_transaction(FUNC_IDLE, 16'h5A5A, 1'b1);
      send_transaction(FUNC_MIC, 16'd7, 1'b1);
      send_transaction(FUNC_RX, 16'hFFFF, 1'b0);
      send_transaction(FUNC_RX, 16'd1, 1'b1);
      send_transaction(FUNC_MIC, SAMPLE_MIN, 1'b1);
      send_transaction(FUNC_IDLE, 16'd0, 1'b0);

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == PHASES - 2)
            calm <= 1'b1;
         case (phase)
            0: apply_settings(12'd4095, 9'd0, 16'd0, 8'd255);
            1: apply_settings(12'd0, DUCK_UNITY, 16'h8000, 8'd0);
            2: apply_settings(12'd256, 9'd1, 16'd32767, 8'd1);
            3: apply_settings(12'd511, 9'd255, 16'd1, 8'd3);
            default: begin
               rxg = ($urandom_range(0, 3) == 0) ? RX_GAIN_RESET : 12'($urandom_range(0, 4095));
               dg = 9'($urandom_range(0, 256));
               thr = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 32768))
                                                 : 16'($urandom_range(0, 4000));
               hang = ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(0, 12));
               apply_settings(rxg, dg, thr, hang);
            end
         endcase

         if (phase == 5 || phase == 8) begin
            // run past the frame size without a frame end
            send_frame(FUNC_RX, FRAME_SAMPLES + 5, pick_level(), 1'b0);
            send_transaction(FUNC_RX, pick_sample(pick_level()), 1'b1);
         end

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            kind = $urandom_range(0, 99);
            len = $urandom_range(1, 24);
            if (kind < 40) begin
               send_frame(FUNC_RX, len, pick_level(), 1'b1);
               sent += len;
            end else if (kind < 80) begin
               send_frame(FUNC_MIC, len, pick_level(), 1'b1);
               sent += len;
            end else if (kind < 85) begin
               send_transaction(FUNC_IDLE, 16'($urandom), 1'($urandom));
               sent++;
            end else if (kind < 88) begin
               send_transaction(FUNC_UNUSED, 16'($urandom), 1'($urandom));
            end else if (kind < 94) begin
               len = $urandom_range(1, 8);
               send_frame(($urandom_range(0, 1) == 0) ? FUNC_RX : FUNC_MIC, len,
                          pick_level(), 1'b0);
               sent += len;
            end else begin
               send_transaction(2'($urandom_range(0, 3)), 16'($urandom), 1'($urandom));
               sent++;
            end
         end
      end

      drain_results();
      if (mismatch_count == 0 && pending_results == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
